>>> sv/quadratic_probe_hash_table_core_assert.svh
// Assertion macros used by the checker file of the hash table core.
`ifndef QUADRATIC_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define QUADRATIC_PROBE_HASH_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QPHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hash table core assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define QPHT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hash table core assertion failed");

`endif

>>> sv/qpht_pkg.sv
// Package of the hash table core: constants, payload types and control codes.
package qpht_pkg;

  localparam int MAX_SLOTS  = 1024;
  localparam int INIT_SLOTS = 16;
  localparam int SLOT_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int STEP_W     = SLOT_W + 2;
  localparam int RAM_DEPTH  = 2 * MAX_SLOTS;
  localparam int RAM_AW     = $clog2(RAM_DEPTH);
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int HASH_W     = 10;
  localparam int TOTAL_W    = 11;

  typedef enum logic [1:0] {
    OP_UPSERT = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_LOOKUP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    op_e                operation;
    logic [KEY_W-1:0]   key;
    logic [HASH_W-1:0]  key_hash;
    logic [VAL_W-1:0]   value;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [VAL_W-1:0]    value_out;
    logic [TOTAL_W-1:0]  entry_total;
  } res_t;

  typedef struct packed {
    logic               occ;
    logic [HASH_W-1:0]  hash;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
  } slot_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_RZ_CLR,
    S_RZ_RD,
    S_RZ_CHK,
    S_RZ_PST,
    S_RZ_PRB,
    S_RZ_SWAP,
    S_PRB_START,
    S_PRB,
    S_FINISH
  } state_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_ACCEPT,
    DP_DECIDE,
    DP_RZ_CLR,
    DP_RZ_RD,
    DP_RZ_LATCH,
    DP_PRB_START,
    DP_PRB_STEP,
    DP_RZ_SWAP,
    DP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   rehash;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic rz_clr_last;
    logic scan_done;
    logic grow;
    logic shrink;
    logic src_occ;
    logic prb_empty;
    logic prb_match;
    logic prb_none;
  } dp_stat_t;

endpackage

>>> sv/quadratic_probe_hash_table_core.sv
// Top level of the quadratic probing key/value hash table.
//
// A request (operation, key, hash, value) is taken at a rising edge where
// start is high and busy is low. Exactly one result follows: res_valid_o is
// high for one cycle with status, value_out and entry_total on res_o, and
// the receiver must take it in that cycle; it cannot hold results off.
// Busy stays high from the request until the result cycle, in which a new
// request may already be given.
// Without a resize a request passes through S_DECIDE, S_PRB_START, S_PRB and
// S_FINISH before its result is registered; the single read port of the slot
// memory gives one probe per cycle.
// A resize before an insert or remove adds its own steps: N new slots are
// cleared, M old slots are scanned, each of the E moved entries gets one set-up
// step and its rehash probes (R in all), and one bank swap follows.
// After reset the block clears all 2048 slot memory entries, one a cycle,
// and holds busy high until that clear is done, before the first request.
module quadratic_probe_hash_table_core import qpht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_valid_o,
  output res_t res_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  qpht_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  qpht_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

>>> sv/qpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/qpht_ctrl.sv
// Controller state machine of the hash table core.
module qpht_ctrl import qpht_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:     if (stat_i.clear_last) state_d = S_IDLE;
      S_IDLE:      if (start_i) state_d = S_DECIDE;
      S_DECIDE: begin
        if (stat_i.grow || stat_i.shrink) state_d = S_RZ_CLR;
        else state_d = S_PRB_START;
      end
      S_RZ_CLR:    if (stat_i.rz_clr_last) state_d = S_RZ_RD;
      S_RZ_RD:     state_d = S_RZ_CHK;
      S_RZ_CHK: begin
        if (stat_i.src_occ) state_d = S_RZ_PST;
        else if (stat_i.scan_done) state_d = S_RZ_SWAP;
        else state_d = S_RZ_RD;
      end
      S_RZ_PST:    state_d = S_RZ_PRB;
      S_RZ_PRB: begin
        if (stat_i.prb_empty || stat_i.prb_none) begin
          state_d = stat_i.scan_done ? S_RZ_SWAP : S_RZ_RD;
        end
      end
      S_RZ_SWAP:   state_d = S_PRB_START;
      S_PRB_START: state_d = S_PRB;
      S_PRB: begin
        if (stat_i.prb_empty || stat_i.prb_match || stat_i.prb_none) state_d = S_FINISH;
      end
      S_FINISH:    state_d = S_IDLE;
      default:     state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o.op     = DP_NOP;
    cmd_o.rehash = 1'b0;
    case (state_q)
      S_CLEAR:     cmd_o.op = DP_CLEAR;
      S_IDLE:      cmd_o.op = start_i ? DP_ACCEPT : DP_NOP;
      S_DECIDE:    cmd_o.op = DP_DECIDE;
      S_RZ_CLR:    cmd_o.op = DP_RZ_CLR;
      S_RZ_RD:     cmd_o.op = DP_RZ_RD;
      S_RZ_CHK:    cmd_o.op = stat_i.src_occ ? DP_RZ_LATCH : DP_NOP;
      S_RZ_PST: begin
        cmd_o.op     = DP_PRB_START;
        cmd_o.rehash = 1'b1;
      end
      S_RZ_PRB: begin
        cmd_o.op     = DP_PRB_STEP;
        cmd_o.rehash = 1'b1;
      end
      S_RZ_SWAP:   cmd_o.op = DP_RZ_SWAP;
      S_PRB_START: cmd_o.op = DP_PRB_START;
      S_PRB:       cmd_o.op = DP_PRB_STEP;
      S_FINISH:    cmd_o.op = DP_FINISH;
      default:     cmd_o.op = DP_NOP;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> sv/qpht_dp.sv
// Datapath of the hash table core: slot memory, probe sequencer and counters.
module qpht_dp import qpht_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dp_cmd_t  cmd_i,
  input  req_t     req_i,
  output dp_stat_t stat_o,
  output logic     res_valid_o,
  output res_t     res_o
);

  // Control registers.
  logic              bank_q, bank_d;
  logic [CNT_W-1:0]  slots_q, slots_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  tgt_slots_q, tgt_slots_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;

  // Payload registers.
  req_t              req_q, req_d;
  slot_t             ent_q, ent_d;
  res_t              res_q, res_d;
  logic [SLOT_W-1:0] home_q, home_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [SLOT_W-1:0] tri_q, tri_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  logic              we, re;
  logic [RAM_AW-1:0] waddr, raddr;
  slot_t             wdata, rdata;

  logic [CNT_W-1:0]    nsel;
  logic [SLOT_W-1:0]   mask, home, tri_nx, next_slot;
  logic [HASH_W-1:0]   hsel;
  logic                bsel;
  logic [CNT_W-1:0]    idx0, idx_nx;
  logic [2*SLOT_W:0]   tri_prod;
  logic [CNT_W+2:0]    load5, slots3, slots2;
  logic                p_empty, p_match, p_none;

  qpht_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Probe geometry follows the destination bank while rehashing.
  assign nsel = cmd_i.rehash ? tgt_slots_q : slots_q;
  assign mask = SLOT_W'(nsel - CNT_W'(1));
  assign hsel = cmd_i.rehash ? ent_q.hash : req_q.key_hash;
  assign bsel = cmd_i.rehash ? ~bank_q : bank_q;
  assign home = SLOT_W'(hsel) & mask;
  assign idx0 = (home != '0) ? CNT_W'(home) : CNT_W'(1);
  assign tri_prod = (2*SLOT_W+1)'(idx0) * (2*SLOT_W+1)'(idx0 + CNT_W'(1));

  always_comb begin
    if (step_q == '0) begin
      idx_nx = idx_q;
      tri_nx = tri_q;
    end else if (idx_q >= nsel) begin
      idx_nx = CNT_W'(1);
      tri_nx = SLOT_W'(1);
    end else begin
      idx_nx = idx_q + CNT_W'(1);
      tri_nx = tri_q + SLOT_W'(idx_q) + SLOT_W'(1);
    end
  end
  assign next_slot = (home_q + tri_nx) & mask;

  assign p_empty = !rdata.occ;
  assign p_match = rdata.occ && !cmd_i.rehash && (rdata.key == req_q.key);
  assign p_none  = !p_empty && !p_match && (step_q == {nsel, 1'b0});

  assign load5  = (CNT_W+3)'(count_q) * (CNT_W+3)'(5);
  assign slots3 = (CNT_W+3)'(slots_q) * (CNT_W+3)'(3);
  assign slots2 = (CNT_W+3)'(slots_q) * (CNT_W+3)'(2);

  always_comb begin
    stat_o.clear_last  = (cnt_q == {CNT_W{1'b1}});
    stat_o.rz_clr_last = (cnt_q[SLOT_W-1:0] == SLOT_W'(tgt_slots_q - CNT_W'(1)));
    stat_o.scan_done   = (cnt_q == slots_q);
    stat_o.grow        = ((req_q.operation == OP_UPSERT) || (req_q.operation == OP_ADD)) &&
                         (load5 >= slots3) && (slots_q < CNT_W'(MAX_SLOTS));
    stat_o.shrink      = (req_q.operation == OP_REMOVE) &&
                         (slots_q > CNT_W'(INIT_SLOTS)) && (load5 <= slots2);
    stat_o.src_occ     = rdata.occ;
    stat_o.prb_empty   = p_empty;
    stat_o.prb_match   = p_match;
    stat_o.prb_none    = p_none;
  end

  always_comb begin
    bank_d      = bank_q;
    slots_d     = slots_q;
    count_d     = count_q;
    tgt_slots_d = tgt_slots_q;
    cnt_d       = cnt_q;
    done_d      = 1'b0;
    req_d       = req_q;
    ent_d       = ent_q;
    res_d       = res_q;
    home_d      = home_q;
    idx_d       = idx_q;
    tri_d       = tri_q;
    step_d      = step_q;
    slot_d      = slot_q;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = {bank_q, slot_q};
    raddr       = {bsel, slot_q};
    wdata       = '0;
    case (cmd_i.op)
      DP_CLEAR: begin
        we    = 1'b1;
        waddr = RAM_AW'(cnt_q);
        cnt_d = cnt_q + CNT_W'(1);
      end
      DP_ACCEPT: req_d = req_i;
      DP_DECIDE: begin
        cnt_d       = '0;
        tgt_slots_d = stat_o.grow ? (slots_q << 1) : (slots_q >> 1);
      end
      DP_RZ_CLR: begin
        we    = 1'b1;
        waddr = {~bank_q, cnt_q[SLOT_W-1:0]};
        cnt_d = stat_o.rz_clr_last ? '0 : cnt_q + CNT_W'(1);
      end
      DP_RZ_RD: begin
        re    = 1'b1;
        raddr = {bank_q, cnt_q[SLOT_W-1:0]};
        cnt_d = cnt_q + CNT_W'(1);
      end
      DP_RZ_LATCH: ent_d = rdata;
      DP_PRB_START: begin
        re     = 1'b1;
        raddr  = {bsel, home};
        home_d = home;
        slot_d = home;
        idx_d  = idx0;
        tri_d  = tri_prod[SLOT_W:1];
        step_d = '0;
      end
      DP_PRB_STEP: begin
        if (cmd_i.rehash && p_empty) begin
          we    = 1'b1;
          waddr = {~bank_q, slot_q};
          wdata = ent_q;
        end
        if (!p_empty && !p_match && !p_none) begin
          re     = 1'b1;
          raddr  = {bsel, next_slot};
          slot_d = next_slot;
          idx_d  = idx_nx;
          tri_d  = tri_nx;
          step_d = step_q + STEP_W'(1);
        end
      end
      DP_RZ_SWAP: begin
        bank_d  = ~bank_q;
        slots_d = tgt_slots_q;
      end
      DP_FINISH: begin
        done_d          = 1'b1;
        res_d.status    = ST_OK;
        res_d.value_out = '0;
        if ((req_q.operation == OP_UPSERT) || (req_q.operation == OP_ADD)) begin
          if (p_none) begin
            res_d.status = ST_FULL;
          end else if (p_match) begin
            if (req_q.operation == OP_UPSERT) begin
              we          = 1'b1;
              wdata       = rdata;
              wdata.value = req_q.value;
            end else begin
              res_d.status = ST_PRESENT;
            end
          end else begin
            we      = 1'b1;
            wdata   = '{occ: 1'b1, hash: req_q.key_hash, key: req_q.key, value: req_q.value};
            count_d = count_q + CNT_W'(1);
          end
        end else begin
          if (!p_match) begin
            res_d.status = ST_NOT_FOUND;
          end else begin
            res_d.value_out = rdata.value;
            if (req_q.operation == OP_REMOVE) begin
              we        = 1'b1;
              wdata     = rdata;
              wdata.occ = 1'b0;
              if (count_q != '0) count_d = count_q - CNT_W'(1);
            end
          end
        end
        res_d.entry_total = TOTAL_W'(count_d);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q      <= 1'b0;
      slots_q     <= CNT_W'(INIT_SLOTS);
      count_q     <= '0;
      tgt_slots_q <= CNT_W'(INIT_SLOTS);
      cnt_q       <= '0;
      done_q      <= 1'b0;
    end else begin
      bank_q      <= bank_d;
      slots_q     <= slots_d;
      count_q     <= count_d;
      tgt_slots_q <= tgt_slots_d;
      cnt_q       <= cnt_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    ent_q  <= ent_d;
    res_q  <= res_d;
    home_q <= home_d;
    idx_q  <= idx_d;
    tri_q  <= tri_d;
    step_q <= step_d;
    slot_q <= slot_d;
  end

  assign res_valid_o = done_q;
  assign res_o       = res_q;

endmodule

>>> sv/qpht_checker.sv
// Port-level checker of the hash table core and its bind statement.
`include "quadratic_probe_hash_table_core_assert.svh"

module qpht_checker import qpht_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic res_valid_o,
  input res_t res_o
);

  // A taken request keeps the block busy until its result.
  `QPHT_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, start && !busy, busy)
  // Results appear only once the block has finished its work.
  `QPHT_ASSERT_IMP(a_idle_on_result, clk_i, rst_ni, res_valid_o, !busy)
  // Each result is a single-cycle strobe.
  `QPHT_ASSERT_NXT(a_single_strobe, clk_i, rst_ni, res_valid_o, !res_valid_o)
  // The entry count never exceeds the largest table.
  `QPHT_ASSERT_IMP(a_total_bound, clk_i, rst_ni, res_valid_o,
                   res_o.entry_total <= 11'(MAX_SLOTS))

endmodule

bind quadratic_probe_hash_table_core qpht_checker u_qpht_checker (.*);
